// ===== design/vmc_pkg.sv =====
// Shared types and constants of the vector magnitude clamp.
package vmc_pkg;

	// Component and vector formats.
	localparam int CW       = 32;
	localparam int BW       = 31;
	localparam int NLANE    = 3;
	localparam int MW       = 32;
	localparam int SQ_STEPS = 32;
	localparam int DV_STEPS = 32;

	typedef logic signed [CW-1:0] comp_t;
	typedef comp_t [NLANE-1:0] vec_t;

	// Status that travels with each beat.
	typedef struct packed {
		logic raised;
		logic cut;
		logic sat;
	} flags_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_MIN_MAG = 1'b0,
		REG_MAX_MAG = 1'b1
	} reg_idx_t;

endpackage

// ===== design/vmc_sqrt.sv =====
// Pipelined sum of squares and bitwise integer square root.
module vmc_sqrt import vmc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  vec_t          in_vec,
	output logic          out_valid,
	output vec_t          out_vec,
	output logic [MW-1:0] out_mag
);

	logic        valid_s1;
	vec_t        vec_s1;
	logic [63:0] sq_s1 [NLANE];

	logic        valid_s [0:SQ_STEPS];
	vec_t        vec_s   [0:SQ_STEPS];
	logic [63:0] v_s     [0:SQ_STEPS];
	logic [63:0] root_s  [0:SQ_STEPS];

	logic [CW-1:0] mag_abs [NLANE];

	// Magnitude of each component; the most negative value maps to 2^31.
	always_comb begin
		for (int l = 0; l < NLANE; l++) begin
			mag_abs[l] = in_vec[l][CW-1] ? CW'(-in_vec[l]) : CW'(in_vec[l]);
		end
	end

	// Valid bits ride along with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			for (int k = 0; k <= SQ_STEPS; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else begin
			valid_s1 <= in_valid;
			valid_s[0] <= valid_s1;
			for (int k = 0; k < SQ_STEPS; k++) begin
				valid_s[k+1] <= valid_s[k];
			end
		end
	end

	// Squares, their sum, then one root bit per stage.
	always_ff @(posedge clk) begin
		vec_s1 <= in_vec;
		for (int l = 0; l < NLANE; l++) begin
			sq_s1[l] <= 64'(mag_abs[l]) * 64'(mag_abs[l]);
		end
		vec_s[0]  <= vec_s1;
		v_s[0]    <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		root_s[0] <= '0;
		for (int k = 0; k < SQ_STEPS; k++) begin
			vec_s[k+1] <= vec_s[k];
			if (v_s[k] >= root_s[k] + (64'd1 << (62 - 2*k))) begin
				v_s[k+1]    <= v_s[k] - (root_s[k] + (64'd1 << (62 - 2*k)));
				root_s[k+1] <= (root_s[k] >> 1) + (64'd1 << (62 - 2*k));
			end else begin
				v_s[k+1]    <= v_s[k];
				root_s[k+1] <= root_s[k] >> 1;
			end
		end
	end

	assign out_valid = valid_s[SQ_STEPS];
	assign out_vec   = vec_s[SQ_STEPS];
	assign out_mag   = root_s[SQ_STEPS][MW-1:0];

endmodule

// ===== design/vmc_scale.sv =====
// Pipelined scaling of a vector by bound / magnitude with saturation.
module vmc_scale import vmc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  vec_t          in_vec,
	input  logic [MW-1:0] in_mag,
	input  flags_t        in_flags,
	input  logic          in_apply,
	input  logic [BW-1:0] bound,
	output logic          out_valid,
	output vec_t          out_vec,
	output logic [MW-1:0] out_mag,
	output flags_t        out_flags
);

	logic          valid_s1;
	vec_t          vec_s1;
	logic [MW-1:0] mag_s1;
	flags_t        flags_s1;
	logic          apply_s1;
	logic [62:0]   prod_s1 [NLANE];

	logic          valid_s [0:DV_STEPS];
	vec_t          vec_s   [0:DV_STEPS];
	logic [MW-1:0] mag_s   [0:DV_STEPS];
	flags_t        flags_s [0:DV_STEPS];
	logic          apply_s [0:DV_STEPS];
	logic [63:0]   rem_s   [0:DV_STEPS][NLANE];
	logic [31:0]   quo_s   [0:DV_STEPS][NLANE];
	logic          big_s   [0:DV_STEPS][NLANE];

	logic          valid_q;
	vec_t          vec_q;
	logic [MW-1:0] mag_q;
	flags_t        flags_q;

	logic [CW-1:0] comp_abs [NLANE];
	vec_t          res_vec;
	logic          res_sat;

	// Component magnitudes.
	always_comb begin
		for (int l = 0; l < NLANE; l++) begin
			comp_abs[l] = in_vec[l][CW-1] ? CW'(-in_vec[l]) : CW'(in_vec[l]);
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
			for (int k = 0; k <= DV_STEPS; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else begin
			valid_s1   <= in_valid;
			valid_s[0] <= valid_s1;
			for (int k = 0; k < DV_STEPS; k++) begin
				valid_s[k+1] <= valid_s[k];
			end
			valid_q <= valid_s[DV_STEPS];
		end
	end

	// Product, overflow precheck, then one quotient bit per stage.
	always_ff @(posedge clk) begin
		vec_s1   <= in_vec;
		mag_s1   <= in_mag;
		flags_s1 <= in_flags;
		apply_s1 <= in_apply;
		for (int l = 0; l < NLANE; l++) begin
			prod_s1[l] <= 63'(comp_abs[l]) * 63'(bound);
		end

		vec_s[0]   <= vec_s1;
		mag_s[0]   <= mag_s1;
		flags_s[0] <= flags_s1;
		apply_s[0] <= apply_s1;
		for (int l = 0; l < NLANE; l++) begin
			rem_s[0][l] <= 64'(prod_s1[l]);
			quo_s[0][l] <= '0;
			big_s[0][l] <= 64'(prod_s1[l]) >= {mag_s1, 32'd0};
		end

		for (int k = 0; k < DV_STEPS; k++) begin
			vec_s[k+1]   <= vec_s[k];
			mag_s[k+1]   <= mag_s[k];
			flags_s[k+1] <= flags_s[k];
			apply_s[k+1] <= apply_s[k];
			for (int l = 0; l < NLANE; l++) begin
				big_s[k+1][l] <= big_s[k][l];
				if (rem_s[k][l] >= (64'(mag_s[k]) << (31 - k))) begin
					rem_s[k+1][l] <= rem_s[k][l] - (64'(mag_s[k]) << (31 - k));
					quo_s[k+1][l] <= quo_s[k][l] | (32'd1 << (31 - k));
				end else begin
					rem_s[k+1][l] <= rem_s[k][l];
					quo_s[k+1][l] <= quo_s[k][l];
				end
			end
		end

		vec_q   <= res_vec;
		mag_q   <= mag_s[DV_STEPS];
		flags_q <= '{raised: flags_s[DV_STEPS].raised, cut: flags_s[DV_STEPS].cut,
			sat: flags_s[DV_STEPS].sat | res_sat};
	end

	// Sign restore and saturation to the signed component range.
	always_comb begin
		res_vec = vec_s[DV_STEPS];
		res_sat = 1'b0;
		if (apply_s[DV_STEPS]) begin
			for (int l = 0; l < NLANE; l++) begin
				if (vec_s[DV_STEPS][l][CW-1]) begin
					if (big_s[DV_STEPS][l] || quo_s[DV_STEPS][l] > 32'h8000_0000) begin
						res_vec[l] = comp_t'(32'h8000_0000);
						res_sat    = 1'b1;
					end else begin
						res_vec[l] = comp_t'(-quo_s[DV_STEPS][l]);
					end
				end else begin
					if (big_s[DV_STEPS][l] || quo_s[DV_STEPS][l] > 32'h7FFF_FFFF) begin
						res_vec[l] = comp_t'(32'h7FFF_FFFF);
						res_sat    = 1'b1;
					end else begin
						res_vec[l] = comp_t'(quo_s[DV_STEPS][l]);
					end
				end
			end
		end
	end

	assign out_valid = valid_q;
	assign out_vec   = vec_q;
	assign out_mag   = mag_q;
	assign out_flags = flags_q;

endmodule

// ===== design/vector_magnitude_clamp.sv =====
// Top level of the 3-D vector magnitude clamp with its register port.
//
// A vector beat (vec_x, vec_y, vec_z, signed Q16.16) is taken at each rising
// edge where start is high and busy is low; busy is always low, so a new
// vector may enter every cycle and the block sustains one vector per cycle.
// Each result (out_x, out_y, out_z and the flags raised_to_min, cut_to_max,
// saturated) appears for exactly one cycle with done high, after its vector
// has passed through 34 stages of squaring and one root bit per stage,
// then 35 stages for the minimum scaling and 35 for the maximum scaling,
// each with one quotient bit per stage. The receiver cannot stall the block,
// and results leave in input order. The bounds min_magnitude (address 0) and
// max_magnitude (address 4) are written over the APB port; the user must write
// them only while no vector is in flight, which the block itself does not
// enforce. pready is always high. Reset clears all valid bits and sets the
// bounds to 0 and 0x7FFFFFFF.
module vector_magnitude_clamp import vmc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] vec_x,
	input  logic [31:0] vec_y,
	input  logic [31:0] vec_z,
	output logic        done,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic [31:0] out_z,
	output logic        raised_to_min,
	output logic        cut_to_max,
	output logic        saturated,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int LAT = 104;

	logic [BW-1:0] min_q;
	logic [BW-1:0] max_q;
	logic          wr_en;
	reg_idx_t      wr_idx;

	vec_t          in_vec;
	logic          sq_valid;
	vec_t          sq_vec;
	logic [MW-1:0] sq_mag;
	logic          mn_valid;
	vec_t          mn_vec;
	logic [MW-1:0] mn_mag;
	flags_t        mn_flags;
	logic          mx_valid;
	vec_t          mx_vec;
	logic [MW-1:0] mx_mag;
	flags_t        mx_flags;
	logic          apply_min;
	logic          apply_max;
	flags_t        min_flags;
	flags_t        max_flags;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign wr_idx = reg_idx_t'(paddr[2]);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= '1;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_MIN_MAG: min_q <= pwdata[BW-1:0];
				REG_MAX_MAG: max_q <= pwdata[BW-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (wr_idx)
			REG_MIN_MAG: prdata = {1'b0, min_q};
			REG_MAX_MAG: prdata = {1'b0, max_q};
			default:     prdata = '0;
		endcase
	end

	assign in_vec = {comp_t'(vec_z), comp_t'(vec_y), comp_t'(vec_x)};

	vmc_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.in_vec    (in_vec),
		.out_valid (sq_valid),
		.out_vec   (sq_vec),
		.out_mag   (sq_mag)
	);

	// Bound decisions use the floored magnitude; a zero vector is never scaled.
	assign apply_min = (sq_mag != '0) && (sq_mag < MW'(min_q));
	assign min_flags = '{raised: apply_min, cut: 1'b0, sat: 1'b0};

	vmc_scale u_scale_min (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.in_vec    (sq_vec),
		.in_mag    (sq_mag),
		.in_flags  (min_flags),
		.in_apply  (apply_min),
		.bound     (min_q),
		.out_valid (mn_valid),
		.out_vec   (mn_vec),
		.out_mag   (mn_mag),
		.out_flags (mn_flags)
	);

	assign apply_max = (mn_mag != '0) && (mn_mag > MW'(max_q));
	assign max_flags = '{raised: mn_flags.raised, cut: apply_max, sat: mn_flags.sat};

	vmc_scale u_scale_max (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mn_valid),
		.in_vec    (mn_vec),
		.in_mag    (mn_mag),
		.in_flags  (max_flags),
		.in_apply  (apply_max),
		.bound     (max_q),
		.out_valid (mx_valid),
		.out_vec   (mx_vec),
		.out_mag   (mx_mag),
		.out_flags (mx_flags)
	);

	assign done          = mx_valid;
	assign out_x         = mx_vec[0];
	assign out_y         = mx_vec[1];
	assign out_z         = mx_vec[2];
	assign raised_to_min = mx_flags.raised;
	assign cut_to_max    = mx_flags.cut;
	assign saturated     = mx_flags.sat & (mx_mag != '0);

	// Saturation only happens when some bound scaled the vector.
	a_sat_needs_scale: assert property (@(posedge clk) disable iff (!arst_n)
		done && saturated |-> raised_to_min || cut_to_max)
		else $error("saturation without scaling");

	// Both bounds act only when the minimum lies above the maximum.
	a_both_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		done && raised_to_min && cut_to_max |-> min_q > max_q)
		else $error("both bounds acted with min not above max");

	// An unscaled vector leaves with its x and z components unchanged after the full latency.
	a_passthrough: assert property (@(posedge clk) disable iff (!arst_n)
		done && !raised_to_min && !cut_to_max |->
			out_x == $past(vec_x, LAT) && out_z == $past(vec_z, LAT))
		else $error("unscaled vector changed");

endmodule
